// ===== sv/ctr_pkg.sv =====
// Shared types, fixed-point constants and rounding helper for the
// colour temperature to RGB pipeline. No dependencies.
package ctr_pkg;

  localparam int FRAC_BITS = 12;
  localparam int IQ = 30;
  localparam int CW = 16;
  localparam int KW = 14;
  localparam int S_QW = 29;
  localparam int CQ_QW = 32;
  localparam int OQW = CW;

  localparam longint ONE = 64'sd1 <<< IQ;

  typedef logic signed [CW-1:0] raw_t;
  typedef logic [63:0] rem_t;
  typedef logic signed [69:0] prod_t;
  typedef logic signed [35:0] acc_t;
  typedef logic signed [35:0] comp_t;
  typedef logic [36:0] lum_t;

  typedef struct packed {
    logic kind;
    raw_t red;
    raw_t green;
    raw_t blue;
  } side_t;

  typedef struct packed {
    side_t side;
    logic hi;
    logic [S_QW-1:0] s;
  } recip_t;

  typedef struct packed {
    comp_t red;
    comp_t green;
    comp_t blue;
  } rgb_t;

  typedef struct packed {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
    logic black;
  } res_t;

  localparam logic [KW-1:0] T_MIN = KW'(4000);
  localparam logic [KW-1:0] T_MAX = KW'(15000);
  localparam logic [KW-1:0] T_SPLIT = KW'(7000);
  localparam longint S_NUM = 1000 * ONE;

  localparam acc_t CA_LO = acc_t'(-((4607 * ONE + 500) / 1000));
  localparam acc_t CB_LO = acc_t'((29678 * ONE + 5000) / 10000);
  localparam acc_t CC_LO = acc_t'((9911 * ONE + 50000) / 100000);
  localparam acc_t CD_LO = acc_t'((244063 * ONE + 500000) / 1000000);
  localparam acc_t CA_HI = acc_t'(-((20064 * ONE + 5000) / 10000));
  localparam acc_t CB_HI = acc_t'((19018 * ONE + 5000) / 10000);
  localparam acc_t CC_HI = acc_t'((24748 * ONE + 50000) / 100000);
  localparam acc_t CD_HI = acc_t'((237040 * ONE + 500000) / 1000000);
  localparam acc_t Y_A = acc_t'((2870 * ONE + 500) / 1000);
  localparam acc_t Y_C = acc_t'((275 * ONE + 500) / 1000);
  localparam acc_t ONE_A = acc_t'(ONE);

  localparam acc_t M00 = acc_t'((32404542 * ONE + 5000000) / 10000000);
  localparam acc_t M01 = acc_t'((15371385 * ONE + 5000000) / 10000000);
  localparam acc_t M02 = acc_t'((4985314 * ONE + 5000000) / 10000000);
  localparam acc_t M10 = acc_t'((9692660 * ONE + 5000000) / 10000000);
  localparam acc_t M11 = acc_t'((18760108 * ONE + 5000000) / 10000000);
  localparam acc_t M12 = acc_t'((415560 * ONE + 5000000) / 10000000);
  localparam acc_t M20 = acc_t'((556434 * ONE + 5000000) / 10000000);
  localparam acc_t M21 = acc_t'((2040259 * ONE + 5000000) / 10000000);
  localparam acc_t M22 = acc_t'((10572252 * ONE + 5000000) / 10000000);

  localparam logic [29:0] W_R = 30'((2126 * ONE + 5000) / 10000);
  localparam logic [29:0] W_G = 30'((7152 * ONE + 5000) / 10000);
  localparam logic [29:0] W_B = 30'((722 * ONE + 5000) / 10000);

  localparam lum_t LUM_MIN = lum_t'((ONE + 999999) / 1000000);
  localparam logic [CW-1:0] WHITE =
    CW'((FRAC_BITS > CW - 1) ? ((1 << CW) - 1) : (1 << FRAC_BITS));
  localparam logic [CW-1:0] HALF_SCALE = CW'(1 << (FRAC_BITS - 1));

  localparam prod_t HALF_P = prod_t'(1) <<< (IQ - 1);

  // round to nearest, halves away from zero, drop IQ fraction bits
  function automatic acc_t rnd_q(input prod_t p);
    prod_t m;
    if (p < 0) begin
      m = -((-p + HALF_P) >>> IQ);
    end else begin
      m = (p + HALF_P) >>> IQ;
    end
    return acc_t'(m);
  endfunction

endpackage

// ===== sv/color_temperature_to_rgb.sv =====
// Top level: colour temperature or raw colour to luminance-normalized sRGB.
// Depends on ctr_pkg, ctr_recip, ctr_locus and ctr_norm.
//
// Takes one beat per clock unless the output stalls it, and returns one result beat per
// input, in order. The pipeline is made of the 1000/T divider (one quotient bit per
// stage), the locus polynomial, chromaticity divider (two lanes, one bit per stage) and
// matrix, and luminance and the 16-bit output divider. Every stage holds its own valid
// bit and stalls only when the stage after it is full, so bubbles close up and input is
// taken while results wait.
module color_temperature_to_rgb (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [ctr_pkg::KW-1:0]       temperature_kelvin_i,
  input  logic signed [ctr_pkg::CW-1:0] red_in_i,
  input  logic signed [ctr_pkg::CW-1:0] green_in_i,
  input  logic signed [ctr_pkg::CW-1:0] blue_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ctr_pkg::CW-1:0]       red_out_o,
  output logic [ctr_pkg::CW-1:0]       green_out_o,
  output logic [ctr_pkg::CW-1:0]       blue_out_o,
  output logic                         black_fallback_o
);

  ctr_pkg::side_t side;
  ctr_pkg::recip_t recip;
  ctr_pkg::rgb_t rgb;
  ctr_pkg::res_t res;
  logic recip_valid, recip_ready, rgb_valid, rgb_ready;

  assign side.kind  = kind_i;
  assign side.red   = red_in_i;
  assign side.green = green_in_i;
  assign side.blue  = blue_in_i;

  ctr_recip u_recip (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .side_i      (side),
    .kelvin_i    (temperature_kelvin_i),
    .out_valid_o (recip_valid),
    .out_ready_i (recip_ready),
    .out_o       (recip)
  );

  ctr_locus u_locus (
    .clk_i,
    .rst_ni,
    .in_valid_i  (recip_valid),
    .in_ready_o  (recip_ready),
    .in_i        (recip),
    .out_valid_o (rgb_valid),
    .out_ready_i (rgb_ready),
    .out_o       (rgb)
  );

  ctr_norm u_norm (
    .clk_i,
    .rst_ni,
    .in_valid_i  (rgb_valid),
    .in_ready_o  (rgb_ready),
    .in_i        (rgb),
    .out_valid_o,
    .out_ready_i,
    .out_o       (res)
  );

  assign red_out_o        = res.red;
  assign green_out_o      = res.green;
  assign blue_out_o       = res.blue;
  assign black_fallback_o = res.black;

endmodule

// ===== sv/ctr_recip.sv =====
// Clamp of the temperature and pipelined restoring divider for 1000/T.
// Depends on ctr_pkg.
module ctr_recip (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ctr_pkg::side_t  side_i,
  input  logic [ctr_pkg::KW-1:0] kelvin_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ctr_pkg::recip_t out_o
);

  localparam int N = ctr_pkg::S_QW + 1;

  logic [N-1:0] v_q, vin, ld;
  logic [N:0] rdy;

  ctr_pkg::side_t side_q [N];
  logic hi_q [N];
  ctr_pkg::rem_t rem_q [N];
  logic [ctr_pkg::KW-1:0] tk_q [N];
  logic [ctr_pkg::S_QW-1:0] q_q [N];

  logic [ctr_pkg::KW-1:0] tk_d;

  assign rdy[N] = out_ready_i;
  for (genvar k = 0; k < N; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign vin = {v_q[N-2:0], in_valid_i};
  assign ld = vin & rdy[N-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~rdy[N-1:0]) | ld;
    end
  end

  always_comb begin
    if (kelvin_i < ctr_pkg::T_MIN) begin
      tk_d = ctr_pkg::T_MIN;
    end else if (kelvin_i > ctr_pkg::T_MAX) begin
      tk_d = ctr_pkg::T_MAX;
    end else begin
      tk_d = kelvin_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      side_q[0] <= side_i;
      hi_q[0]   <= tk_d > ctr_pkg::T_SPLIT;
      tk_q[0]   <= tk_d;
      rem_q[0]  <= ctr_pkg::rem_t'(ctr_pkg::S_NUM) + ctr_pkg::rem_t'(tk_d >> 1);
      q_q[0]    <= '0;
    end
  end

  for (genvar k = 1; k < N; k++) begin : g_div
    localparam int SHIFT = ctr_pkg::S_QW - k;
    ctr_pkg::rem_t dsh;
    logic ge;
    assign dsh = ctr_pkg::rem_t'(tk_q[k-1]) << SHIFT;
    assign ge = rem_q[k-1] >= dsh;
    always_ff @(posedge clk_i) begin
      if (ld[k]) begin
        side_q[k] <= side_q[k-1];
        hi_q[k]   <= hi_q[k-1];
        tk_q[k]   <= tk_q[k-1];
        rem_q[k]  <= ge ? rem_q[k-1] - dsh : rem_q[k-1];
        q_q[k]    <= {q_q[k-1][ctr_pkg::S_QW-2:0], ge};
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[N-1];
  assign out_o.side  = side_q[N-1];
  assign out_o.hi    = hi_q[N-1];
  assign out_o.s     = q_q[N-1];

endmodule

// ===== sv/ctr_locus.sv =====
// Daylight locus cubic, chromaticity to XYZ division and XYZ to sRGB matrix,
// merged with the raw colour path. Depends on ctr_pkg.
module ctr_locus (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ctr_pkg::recip_t in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ctr_pkg::rgb_t   out_o
);

  localparam int QW = ctr_pkg::CQ_QW;
  localparam int DIV0 = 9;
  localparam int MM = DIV0 + QW;
  localparam int MS = MM + 1;
  localparam int N = MS + 1;
  localparam int RAW_SH = ctr_pkg::IQ - ctr_pkg::FRAC_BITS;

  logic [N-1:0] v_q, vin, ld;
  logic [N:0] rdy;

  ctr_pkg::side_t side_q [N];
  logic hi_q [5];
  logic [ctr_pkg::S_QW-1:0] s_q [4];
  ctr_pkg::prod_t p0_q, p2_q, p4_q, p6_q;
  ctr_pkg::acc_t a1_q, a3_q, x5_q, x6_q, x7_q, y7_q;
  ctr_pkg::rem_t rx_q [DIV0-1:MM-1];
  ctr_pkg::rem_t rz_q [DIV0-1:MM-1];
  logic [QW-1:0] qx_q [DIV0-1:MM-1];
  logic [QW-1:0] qz_q [DIV0-1:MM-1];
  logic [31:0] dy_q [DIV0-1:MM-1];
  ctr_pkg::prod_t pm_q [6];
  ctr_pkg::rgb_t rgb_q;

  ctr_pkg::acc_t ca_d, t1_d, y_d, z_d;
  logic signed [65:0] pr0, pr2, pr4;
  logic signed [64:0] pr6;
  logic signed [68:0] prm [6];
  logic signed [32:0] cx_d, cz_d;
  ctr_pkg::rgb_t rgb_d;

  assign rdy[N] = out_ready_i;
  for (genvar k = 0; k < N; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign vin = {v_q[N-2:0], in_valid_i};
  assign ld = vin & rdy[N-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~rdy[N-1:0]) | ld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      side_q[0] <= in_i.side;
    end
  end
  for (genvar k = 1; k < N; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (ld[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_comb begin
    ca_d = in_i.hi ? ctr_pkg::CA_HI : ctr_pkg::CA_LO;
    t1_d = ctr_pkg::Y_A - (x5_q + (x5_q <<< 1));
    y_d  = ctr_pkg::rnd_q(p6_q) - ctr_pkg::Y_C;
    z_d  = ctr_pkg::ONE_A - x7_q - y7_q;
  end

  assign pr0 = ca_d * $signed({1'b0, in_i.s});
  assign pr2 = a1_q * $signed({1'b0, s_q[1]});
  assign pr4 = a3_q * $signed({1'b0, s_q[3]});
  assign pr6 = $signed(t1_d[32:0]) * $signed(x5_q[31:0]);

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      p0_q <= ctr_pkg::prod_t'(pr0);
      s_q[0] <= in_i.s;
      hi_q[0] <= in_i.hi;
    end
    if (ld[1]) begin
      a1_q <= ctr_pkg::rnd_q(p0_q) + (hi_q[0] ? ctr_pkg::CB_HI : ctr_pkg::CB_LO);
      s_q[1] <= s_q[0];
      hi_q[1] <= hi_q[0];
    end
    if (ld[2]) begin
      p2_q <= ctr_pkg::prod_t'(pr2);
      s_q[2] <= s_q[1];
      hi_q[2] <= hi_q[1];
    end
    if (ld[3]) begin
      a3_q <= ctr_pkg::rnd_q(p2_q) + (hi_q[2] ? ctr_pkg::CC_HI : ctr_pkg::CC_LO);
      s_q[3] <= s_q[2];
      hi_q[3] <= hi_q[2];
    end
    if (ld[4]) begin
      p4_q <= ctr_pkg::prod_t'(pr4);
      hi_q[4] <= hi_q[3];
    end
    if (ld[5]) begin
      x5_q <= ctr_pkg::rnd_q(p4_q) + (hi_q[4] ? ctr_pkg::CD_HI : ctr_pkg::CD_LO);
    end
    if (ld[6]) begin
      p6_q <= ctr_pkg::prod_t'(pr6);
      x6_q <= x5_q;
    end
    if (ld[7]) begin
      y7_q <= (y_d < 1) ? ctr_pkg::acc_t'(1) : y_d;
      x7_q <= x6_q;
    end
    if (ld[8]) begin
      rx_q[8] <= (ctr_pkg::rem_t'(x7_q) << ctr_pkg::IQ) + ctr_pkg::rem_t'(y7_q >>> 1);
      rz_q[8] <= (ctr_pkg::rem_t'(z_d) << ctr_pkg::IQ) + ctr_pkg::rem_t'(y7_q >>> 1);
      qx_q[8] <= '0;
      qz_q[8] <= '0;
      dy_q[8] <= y7_q[31:0];
    end
  end

  for (genvar k = DIV0; k < MM; k++) begin : g_div
    localparam int SHIFT = QW - 1 - (k - DIV0);
    ctr_pkg::rem_t dsh;
    logic gx, gz;
    assign dsh = ctr_pkg::rem_t'(dy_q[k-1]) << SHIFT;
    assign gx = rx_q[k-1] >= dsh;
    assign gz = rz_q[k-1] >= dsh;
    always_ff @(posedge clk_i) begin
      if (ld[k]) begin
        rx_q[k] <= gx ? rx_q[k-1] - dsh : rx_q[k-1];
        rz_q[k] <= gz ? rz_q[k-1] - dsh : rz_q[k-1];
        qx_q[k] <= {qx_q[k-1][QW-2:0], gx};
        qz_q[k] <= {qz_q[k-1][QW-2:0], gz};
        dy_q[k] <= dy_q[k-1];
      end
    end
  end

  assign cx_d = $signed({1'b0, qx_q[MM-1]});
  assign cz_d = $signed({1'b0, qz_q[MM-1]});
  assign prm[0] = ctr_pkg::M00 * cx_d;
  assign prm[1] = ctr_pkg::M02 * cz_d;
  assign prm[2] = ctr_pkg::M10 * cx_d;
  assign prm[3] = ctr_pkg::M12 * cz_d;
  assign prm[4] = ctr_pkg::M20 * cx_d;
  assign prm[5] = ctr_pkg::M22 * cz_d;

  always_ff @(posedge clk_i) begin
    if (ld[MM]) begin
      for (int i = 0; i < 6; i++) begin
        pm_q[i] <= ctr_pkg::prod_t'(prm[i]);
      end
    end
  end

  always_comb begin
    if (side_q[MM].kind) begin
      rgb_d.red   = ctr_pkg::comp_t'(side_q[MM].red) <<< RAW_SH;
      rgb_d.green = ctr_pkg::comp_t'(side_q[MM].green) <<< RAW_SH;
      rgb_d.blue  = ctr_pkg::comp_t'(side_q[MM].blue) <<< RAW_SH;
    end else begin
      rgb_d.red   = ctr_pkg::rnd_q(pm_q[0]) - ctr_pkg::M01 - ctr_pkg::rnd_q(pm_q[1]);
      rgb_d.green = ctr_pkg::M11 - ctr_pkg::rnd_q(pm_q[2]) + ctr_pkg::rnd_q(pm_q[3]);
      rgb_d.blue  = ctr_pkg::rnd_q(pm_q[4]) - ctr_pkg::M21 + ctr_pkg::rnd_q(pm_q[5]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[MS]) begin
      rgb_q <= rgb_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[N-1];
  assign out_o       = rgb_q;

endmodule

// ===== sv/ctr_norm.sv =====
// Clip, Rec.709 luminance and pipelined division of each component by it.
// Depends on ctr_pkg.
module ctr_norm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ctr_pkg::rgb_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ctr_pkg::res_t out_o
);

  localparam int QW = ctr_pkg::OQW;
  localparam int DIV0 = 3;
  localparam int OUT = DIV0 + QW;
  localparam int N = OUT + 1;
  localparam logic [29:0] W_LUM [3] = '{ctr_pkg::W_R, ctr_pkg::W_G, ctr_pkg::W_B};

  logic [N-1:0] v_q, vin, ld;
  logic [N:0] rdy;

  logic [34:0] c_q [2][3];
  logic [64:0] pw_q [3];
  ctr_pkg::lum_t lum_q;
  ctr_pkg::rem_t rem_q [DIV0-1:OUT-1][3];
  logic [QW-1:0] q_q [DIV0-1:OUT-1][3];
  ctr_pkg::lum_t dl_q [DIV0-1:OUT-1];
  logic [2:0] sat_q [DIV0-1:OUT-1];
  logic fb_q [DIV0-1:OUT-1];
  ctr_pkg::res_t res_q;

  ctr_pkg::comp_t comp [3];
  logic [34:0] c_d [3];
  logic [66:0] sum_d;
  ctr_pkg::rem_t n_d [3];
  logic [QW-1:0] o_d [3];

  assign rdy[N] = out_ready_i;
  for (genvar k = 0; k < N; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign vin = {v_q[N-2:0], in_valid_i};
  assign ld = vin & rdy[N-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~rdy[N-1:0]) | ld;
    end
  end

  always_comb begin
    comp[0] = in_i.red;
    comp[1] = in_i.green;
    comp[2] = in_i.blue;
    for (int i = 0; i < 3; i++) begin
      c_d[i] = (comp[i] > 0) ? comp[i][34:0] : '0;
    end
    sum_d = 67'(pw_q[0]) + 67'(pw_q[1]) + 67'(pw_q[2]) + (67'd1 << (ctr_pkg::IQ - 1));
    for (int i = 0; i < 3; i++) begin
      n_d[i] = (ctr_pkg::rem_t'(c_q[1][i]) << ctr_pkg::FRAC_BITS)
             + ctr_pkg::rem_t'(lum_q >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      for (int i = 0; i < 3; i++) begin
        c_q[0][i] <= c_d[i];
        pw_q[i]   <= W_LUM[i] * c_d[i];
      end
    end
    if (ld[1]) begin
      c_q[1] <= c_q[0];
      lum_q  <= ctr_pkg::lum_t'(sum_d >> ctr_pkg::IQ);
    end
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[2][i] <= n_d[i];
        q_q[2][i]   <= '0;
        sat_q[2][i] <= n_d[i] >= (ctr_pkg::rem_t'(lum_q) << QW);
      end
      dl_q[2] <= lum_q;
      fb_q[2] <= lum_q < ctr_pkg::LUM_MIN;
    end
  end

  for (genvar k = DIV0; k < OUT; k++) begin : g_div
    localparam int SHIFT = QW - 1 - (k - DIV0);
    ctr_pkg::rem_t dsh;
    logic [2:0] ge;
    assign dsh = ctr_pkg::rem_t'(dl_q[k-1]) << SHIFT;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = rem_q[k-1][i] >= dsh;
      end
    end
    always_ff @(posedge clk_i) begin
      if (ld[k]) begin
        for (int i = 0; i < 3; i++) begin
          rem_q[k][i] <= ge[i] ? rem_q[k-1][i] - dsh : rem_q[k-1][i];
          q_q[k][i]   <= {q_q[k-1][i][QW-2:0], ge[i]};
        end
        dl_q[k]  <= dl_q[k-1];
        sat_q[k] <= sat_q[k-1];
        fb_q[k]  <= fb_q[k-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fb_q[OUT-1]) begin
        o_d[i] = ctr_pkg::WHITE;
      end else if (sat_q[OUT-1][i]) begin
        o_d[i] = '1;
      end else begin
        o_d[i] = q_q[OUT-1][i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[OUT]) begin
      res_q.red   <= o_d[0];
      res_q.green <= o_d[1];
      res_q.blue  <= o_d[2];
      res_q.black <= fb_q[OUT-1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[N-1];
  assign out_o       = res_q;

endmodule

// ===== sv/ctr_checker.sv =====
// Port-level checks for color_temperature_to_rgb, bound to the top level.
// Depends on ctr_pkg.
module ctr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ctr_pkg::CW-1:0]        red_out_o,
  input logic [ctr_pkg::CW-1:0]        green_out_o,
  input logic [ctr_pkg::CW-1:0]        blue_out_o,
  input logic                          black_fallback_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o)
      && $stable(green_out_o) && $stable(blue_out_o) && $stable(black_fallback_o))
    else $error("stalled result beat changed");

  a_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && black_fallback_o |-> red_out_o == ctr_pkg::WHITE
      && green_out_o == ctr_pkg::WHITE && blue_out_o == ctr_pkg::WHITE)
    else $error("fallback beat is not white");

  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !black_fallback_o |-> red_out_o >= ctr_pkg::HALF_SCALE
      || green_out_o >= ctr_pkg::HALF_SCALE || blue_out_o >= ctr_pkg::HALF_SCALE)
    else $error("normalized beat has no channel near unity");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

endmodule

bind color_temperature_to_rgb ctr_checker u_ctr_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for color_temperature_to_rgb: temperature and raw colour beats
// are checked against a fixed-point predictor of the daylight locus and luminance normalize.
// Depends on ctr_pkg and the color_temperature_to_rgb RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef enum logic {KIND_TEMP = 1'b0, KIND_RAW = 1'b1} kind_e;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        black;
  } color_t;

  typedef struct {
    kind_e           kind;
    logic [13:0]     kelvin;
    logic [15:0]     r;
    logic [15:0]     g;
    logic [15:0]     b;
    bit              known;
    color_t          res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic kind_i = 1'b0;
  logic [ctr_pkg::KW-1:0] temperature_kelvin_i = '0;
  logic signed [ctr_pkg::CW-1:0] red_in_i = '0;
  logic signed [ctr_pkg::CW-1:0] green_in_i = '0;
  logic signed [ctr_pkg::CW-1:0] blue_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ctr_pkg::CW-1:0] red_out_o, green_out_o, blue_out_o;
  logic black_fallback_o;

  color_temperature_to_rgb i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  color_t pending_colors[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int wdog = 0;

  localparam longint Q1 = 64'sd1 << 30;

  function automatic longint qconst(longint num, longint den);
    return (num * Q1 + den / 2) / den;
  endfunction

  function automatic longint rdiv(longint n, longint d);
    if (d <= 0) d = 1;
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rdiv(a * b, Q1);
  endfunction

  function automatic color_t normalize_color(kind_e kind, logic [13:0] kelvin,
                                             logic [15:0] r, logic [15:0] g,
                                             logic [15:0] b);
    longint lin[3];
    longint clip[3];
    longint t, s, ca, cb, cc, cd, x, y, cx, cz, lum, q;
    color_t res;
    if (kind == KIND_TEMP) begin
      t = kelvin;
      if (t < 4000) t = 4000;
      if (t > 15000) t = 15000;
      s = rdiv(1000 * Q1, t);
      if (t <= 7000) begin
        ca = -qconst(4607, 1000); cb = qconst(29678, 10000);
        cc = qconst(9911, 100000); cd = qconst(244063, 1000000);
      end else begin
        ca = -qconst(20064, 10000); cb = qconst(19018, 10000);
        cc = qconst(24748, 100000); cd = qconst(237040, 1000000);
      end
      x = qmul(qmul(qmul(ca, s) + cb, s) + cc, s) + cd;
      y = qmul(qmul(-qconst(3, 1), x) + qconst(2870, 1000), x) - qconst(275, 1000);
      if (y < 1) y = 1;
      cx = rdiv(x * Q1, y);
      cz = rdiv((Q1 - x - y) * Q1, y);
      lin[0] = qmul(qconst(32404542, 10000000), cx) - qconst(15371385, 10000000)
             - qmul(qconst(4985314, 10000000), cz);
      lin[1] = -qmul(qconst(9692660, 10000000), cx) + qconst(18760108, 10000000)
             + qmul(qconst(415560, 10000000), cz);
      lin[2] = qmul(qconst(556434, 10000000), cx) - qconst(2040259, 10000000)
             + qmul(qconst(10572252, 10000000), cz);
    end else begin
      lin[0] = longint'($signed(r)) * (64'sd1 << 18);
      lin[1] = longint'($signed(g)) * (64'sd1 << 18);
      lin[2] = longint'($signed(b)) * (64'sd1 << 18);
    end
    for (int i = 0; i < 3; i++) clip[i] = lin[i] > 0 ? lin[i] : 0;
    lum = qconst(2126, 10000) * clip[0] + qconst(7152, 10000) * clip[1]
        + qconst(722, 10000) * clip[2];
    lum = (lum + (64'sd1 << 29)) >>> 30;
    if (lum * 1000000 < Q1) begin
      res = '{16'd4096, 16'd4096, 16'd4096, 1'b1};
    end else begin
      q = ((clip[0] << 12) + lum / 2) / lum; res.red = q > 65535 ? 16'hffff : q[15:0];
      q = ((clip[1] << 12) + lum / 2) / lum; res.green = q > 65535 ? 16'hffff : q[15:0];
      q = ((clip[2] << 12) + lum / 2) / lum; res.blue = q > 65535 ? 16'hffff : q[15:0];
      res.black = 1'b0;
    end
    return res;
  endfunction

  task automatic report(string what, color_t got, color_t want);
    errors++;
    $display("MISMATCH %s: got %h %h %h %b want %h %h %h %b", what, got.red, got.green,
             got.blue, got.black, want.red, want.green, want.blue, want.black);
  endtask

  task automatic send_beat(kind_e kind, logic [13:0] kelvin, logic [15:0] r,
                           logic [15:0] g, logic [15:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    temperature_kelvin_i <= kelvin;
    red_in_i <= r;
    green_in_i <= g;
    blue_in_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    color_t got, want;
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) wdog <= 0;
      else wdog <= wdog + 1;
      if (in_valid_i && in_ready_o)
        pending_colors.push_back(normalize_color(kind_e'(kind_i), temperature_kelvin_i,
                                                 red_in_i, green_in_i, blue_in_i));
      if (out_valid_o && out_ready_i) begin
        got = '{red_out_o, green_out_o, blue_out_o, black_fallback_o};
        if (pending_colors.size() == 0) begin
          report("unexpected beat", got, got);
        end else begin
          want = pending_colors.pop_front();
          if (got.red !== want.red) report("red", got, want);
          if (got.green !== want.green) report("green", got, want);
          if (got.blue !== want.blue) report("blue", got, want);
          if (got.black !== want.black) report("black", got, want);
        end
      end
      if (wdog >= WDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  row_t directed[$];
  color_t typed_colors[$];

  task automatic add_row(kind_e kind, int kelvin, int r, int g, int b, bit known,
                         color_t res);
    row_t row;
    row.kind = kind; row.kelvin = 14'(kelvin); row.r = 16'(r); row.g = 16'(g);
    row.b = 16'(b);
    row.known = known; row.res = res;
    directed.push_back(row);
  endtask

  task automatic random_beats(int count);
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(9);
      if (sel < 4)
        send_beat(KIND_TEMP, 14'($urandom_range(4000, 15000)), 16'($urandom),
                  16'($urandom), 16'($urandom));
      else if (sel < 5)
        send_beat(KIND_TEMP, 14'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
      else if (sel < 8)
        send_beat(KIND_RAW, 14'($urandom), 16'($urandom_range(0, 16384)),
                  16'($urandom_range(0, 16384)), 16'($urandom_range(0, 16384)));
      else if (sel < 9)
        send_beat(KIND_RAW, 14'($urandom), 16'($urandom_range(0, 4)),
                  16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)));
      else
        send_beat(KIND_RAW, 14'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
    end
  endtask

  initial begin
    color_t white, zero;
    white = '{16'd4096, 16'd4096, 16'd4096, 1'b1};
    zero = '0;
    add_row(KIND_TEMP, 0, 0, 0, 0, 0, zero);
    add_row(KIND_TEMP, 3999, 16'hffff, 16'hffff, 16'hffff, 0, zero);
    add_row(KIND_TEMP, 4000, 0, 0, 0, 0, zero);
    add_row(KIND_TEMP, 7000, 0, 0, 0, 0, zero);
    add_row(KIND_TEMP, 7001, 0, 0, 0, 0, zero);
    add_row(KIND_TEMP, 15000, 0, 0, 0, 0, zero);
    add_row(KIND_TEMP, 16383, 0, 0, 0, 0, zero);
    add_row(KIND_RAW, 16383, 0, 0, 0, 1, white);
    add_row(KIND_RAW, 0, 16'h8000, 16'h8000, 16'h8000, 1, white);
    add_row(KIND_RAW, 0, 16'hffff, 16'hffff, 16'hffff, 1, white);
    add_row(KIND_RAW, 0, 1, 1, 1, 0, zero);
    add_row(KIND_RAW, 0, 4096, 4096, 4096, 1, '{16'd4096, 16'd4096, 16'd4096, 1'b0});
    add_row(KIND_RAW, 0, 16'h7fff, 16'h7fff, 16'h7fff, 0, zero);
    add_row(KIND_RAW, 0, 16'h7fff, 0, 0, 0, zero);
    add_row(KIND_RAW, 0, 0, 16'h7fff, 0, 0, zero);
    add_row(KIND_RAW, 0, 0, 0, 16'h7fff, 0, zero);
    add_row(KIND_RAW, 0, 16'h7fff, 1, 0, 0, zero);
    add_row(KIND_RAW, 0, 0, 0, 1, 0, zero);
    add_row(KIND_RAW, 0, 16'h8000, 4096, 16'h7fff, 0, zero);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 6; recv_idle_pct = 70;
    foreach (directed[i]) begin
      if (directed[i].known) typed_colors.push_back(directed[i].res);
      send_beat(directed[i].kind, directed[i].kelvin, directed[i].r, directed[i].g,
                directed[i].b);
      if (directed[i].known) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        if (pending_colors.size() > 0 && pending_colors[$] !== typed_colors[$]) begin
          errors++;
          $display("MISMATCH typed row %0d disagrees with predictor", i);
        end
      end
    end
    random_beats(250);
    send_idle_pct = 70; recv_idle_pct = 6;
    random_beats(260);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_beats(270);
    in_valid_i <= 1'b0;
    while (pending_colors.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
